// ----- rtl/core/ssrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssrc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SRC_RATE_W  = 16;
   localparam int DST_RATE_W  = 18;
   localparam int LEN_W       = 14;
   localparam int SLOT_W      = 13;
   localparam int ERR_W       = 21;
   localparam int STRIDE_W    = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SOURCE_RATE   = 8'd0,
      REG_DEST_RATE     = 8'd1,
      REG_WORD_SWAP     = 8'd2,
      REG_BUFFER_LENGTH = 8'd3
   } reg_index_type;

   localparam logic [SRC_RATE_W-1:0] RESET_SOURCE_RATE   = 16'd16800;
   localparam logic [DST_RATE_W-1:0] RESET_DEST_RATE     = 18'd22050;
   localparam logic                  RESET_WORD_SWAP     = 1'b0;
   localparam logic [LEN_W-1:0]      RESET_BUFFER_LENGTH = 14'd2048;

   // error term and rounded stride for the reset rates
   localparam logic signed [ERR_W-1:0] RESET_ERROR =
      ERR_W'(2 * int'(RESET_SOURCE_RATE) - int'(RESET_DEST_RATE));
   localparam logic [STRIDE_W-1:0] RESET_STRIDE =
      STRIDE_W'((2 * int'(RESET_SOURCE_RATE) + int'(RESET_DEST_RATE))
                / (2 * int'(RESET_DEST_RATE)));
   localparam logic [STRIDE_W-1:0] STRIDE_MAX = '1;

   typedef struct packed {
      logic [SRC_RATE_W-1:0] source_rate;
      logic [DST_RATE_W-1:0] dest_rate;
      logic                  word_swap;
      logic [LEN_W-1:0]      buffer_length;
   } cfg_type;

   typedef struct packed {
      logic                busy;
      logic [STRIDE_W-1:0] stride;
   } stride_stat_type;

   // 2*source - dest, the value the error term restarts from
   function automatic logic signed [ERR_W-1:0] restart_value(
      input logic [SRC_RATE_W-1:0] src,
      input logic [DST_RATE_W-1:0] dst
   );
      return $signed(ERR_W'({src, 1'b0})) - $signed(ERR_W'(dst));
   endfunction

   // zero acts as one, anything above the buffer size acts as the buffer size
   function automatic logic [LEN_W-1:0] eff_length(
      input logic [LEN_W-1:0] len,
      input logic [LEN_W-1:0] max_len
   );
      logic [LEN_W-1:0] res;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > max_len) begin
         res = max_len;
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssrc_stride_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssrc_stride_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire ssrc_pkg::cfg_type         cfg,
   output      ssrc_pkg::stride_stat_type stat
);

   localparam int STRIDE_W = ssrc_pkg::STRIDE_W;
   localparam int NUM_W    = ssrc_pkg::DST_RATE_W + 1;
   localparam int SH_W     = NUM_W + STRIDE_W;
   localparam int BIT_W    = $clog2(STRIDE_W);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_LOAD,
      DIV_RUN
   } div_state_type;

   div_state_type       state_ff, state_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [SH_W-1:0]     dsh_ff, dsh_in;
   logic [STRIDE_W-1:0] quo_ff, quo_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;

   logic [NUM_W-1:0] numer;
   logic [NUM_W-1:0] denom;
   logic             sat;
   logic             ge;
   logic [SH_W-1:0]  diff;

   // rounded quotient (2s + d) / (2d)
   assign numer = NUM_W'({cfg.source_rate, 1'b0}) + NUM_W'(cfg.dest_rate);
   assign denom = NUM_W'({cfg.dest_rate, 1'b0});
   assign sat   = SH_W'(numer) >= {denom, STRIDE_W'(0)};
   assign ge    = SH_W'(rem_ff) >= dsh_ff;
   assign diff  = SH_W'(rem_ff) - dsh_ff;

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      bit_in    = bit_ff;
      stride_in = stride_ff;
      unique case (state_ff)
         DIV_IDLE: begin
         end
         DIV_LOAD: begin
            if (sat) begin
               stride_in = ssrc_pkg::STRIDE_MAX;
               state_in  = DIV_IDLE;
            end else begin
               rem_in   = numer;
               dsh_in   = SH_W'({denom, (STRIDE_W - 1)'(0)});
               quo_in   = '0;
               bit_in   = BIT_W'(STRIDE_W - 1);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (ge) begin
               rem_in = NUM_W'(diff);
            end
            quo_in = {quo_ff[STRIDE_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               // a stride that rounds to nothing still moves one frame
               stride_in = (quo_in == '0) ? STRIDE_W'(1) : quo_in;
               state_in  = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
      if (start) begin
         state_in = DIV_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= DIV_IDLE;
         stride_ff <= ssrc_pkg::RESET_STRIDE;
      end else begin
         state_ff  <= state_in;
         stride_ff <= stride_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign stat.busy   = state_ff != DIV_IDLE;
   assign stat.stride = stride_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ssrc_frame_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssrc_frame_core #(
   parameter int MAX_BUFFER_FRAMES = 8192,
   parameter int MAX_REPEAT        = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ssrc_pkg::cfg_type                     cfg,
   input  wire logic [ssrc_pkg::STRIDE_W-1:0]         stride,
   input  wire logic                                  in_take,
   input  wire logic signed [ssrc_pkg::SAMPLE_W-1:0]  in_first_word,
   input  wire logic signed [ssrc_pkg::SAMPLE_W-1:0]  in_second_word,
   input  wire logic                                  in_chunk_start,
   output      logic                                  in_ready,
   output      logic                                  out_valid,
   input  wire logic                                  out_stall,
   output      logic signed [ssrc_pkg::SAMPLE_W-1:0]  out_low_slot_sample,
   output      logic signed [ssrc_pkg::SAMPLE_W-1:0]  out_high_slot_sample,
   output      logic [ssrc_pkg::SLOT_W-1:0]           out_slot_position,
   output      logic                                  out_buffer_full,
   output      logic                                  out_last_of_run
);

   localparam int POS_W      = $clog2(MAX_BUFFER_FRAMES);
   localparam int CNT_W      = $clog2(MAX_REPEAT + 1);
   localparam int ERR_W      = ssrc_pkg::ERR_W;
   localparam int LEN_W      = ssrc_pkg::LEN_W;
   localparam int OUT_SLOT_W = ssrc_pkg::SLOT_W;
   localparam int STRIDE_W   = ssrc_pkg::STRIDE_W;
   localparam int SAMPLE_W   = ssrc_pkg::SAMPLE_W;

   // input stage
   logic                       item_valid_ff, item_valid_in;
   logic signed [SAMPLE_W-1:0] first_ff, first_in;
   logic signed [SAMPLE_W-1:0] second_ff, second_in;
   logic                       start_ff, start_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   // stepping state
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [STRIDE_W-1:0]     skip_ff, skip_in;
   logic [POS_W-1:0]        pos_ff, pos_in;

   // result stage
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] low_ff, low_in;
   logic signed [SAMPLE_W-1:0] high_ff, high_in;
   logic [OUT_SLOT_W-1:0]      slot_ff, slot_in;
   logic                       full_ff, full_in;
   logic                       last_ff, last_in;

   logic                    up_mode;
   logic signed [ERR_W-1:0] restart;
   logic signed [ERR_W-1:0] step_adv;
   logic signed [ERR_W-1:0] step_hold;
   logic signed [ERR_W-1:0] cur_err;
   logic [STRIDE_W-1:0]     cur_skip;
   logic [CNT_W-1:0]        cnt_next;
   logic                    rep_cap;
   logic                    up_done;
   logic                    emit_want;
   logic                    run_done;
   logic                    out_free;
   logic                    step;
   logic                    emit;
   logic [LEN_W-1:0]        len;
   logic [LEN_W-1:0]        pos_next;
   logic                    wrap;

   assign up_mode   = cfg.dest_rate > ssrc_pkg::DST_RATE_W'(cfg.source_rate);
   assign restart   = ssrc_pkg::restart_value(cfg.source_rate, cfg.dest_rate);
   assign step_hold = $signed(ERR_W'({cfg.source_rate, 1'b0}));
   assign step_adv  = step_hold - $signed(ERR_W'({cfg.dest_rate, 1'b0}));

   // a chunk start restarts the error term and the stride on the frame's first step
   assign cur_err   = start_ff ? restart : err_ff;
   assign cur_skip  = start_ff ? '0 : skip_ff;
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign rep_cap   = cnt_next >= CNT_W'(MAX_REPEAT);
   assign up_done   = !cur_err[ERR_W-1] || rep_cap;
   assign emit_want = up_mode || (cur_skip == '0);
   assign run_done  = up_mode ? up_done : 1'b1;

   assign out_free  = !rsp_valid_ff || !out_stall;
   assign step      = item_valid_ff && (out_free || !emit_want);
   assign emit      = step && emit_want;
   assign in_ready  = !item_valid_ff || (step && run_done);

   assign len      = ssrc_pkg::eff_length(cfg.buffer_length, LEN_W'(MAX_BUFFER_FRAMES));
   assign pos_next = LEN_W'(pos_ff) + LEN_W'(1);
   assign wrap     = pos_next >= len;

   always_comb begin
      item_valid_in = item_valid_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      start_in      = start_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      skip_in       = skip_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      slot_in       = slot_ff;
      full_in       = full_ff;
      last_in       = last_ff;

      if (step) begin
         start_in = 1'b0;
         if (up_mode) begin
            skip_in = '0;
            priority if (!cur_err[ERR_W-1]) begin
               err_in = cur_err + step_adv;
            end else if (rep_cap) begin
               // leave the frame anyway, restart the term
               err_in = restart;
            end else begin
               err_in = cur_err + step_hold;
            end
            cnt_in = up_done ? '0 : cnt_next;
         end else begin
            err_in  = cur_err;
            cnt_in  = '0;
            skip_in = emit_want ? (stride - STRIDE_W'(1)) : (cur_skip - STRIDE_W'(1));
         end
         if (run_done) begin
            item_valid_in = 1'b0;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         low_in       = cfg.word_swap ? first_ff : second_ff;
         high_in      = cfg.word_swap ? second_ff : first_ff;
         slot_in      = OUT_SLOT_W'(pos_ff);
         full_in      = wrap;
         last_in      = run_done;
         pos_in       = wrap ? '0 : POS_W'(pos_next);
      end else if (!out_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (in_take) begin
         item_valid_in = 1'b1;
         first_in      = in_first_word;
         second_in     = in_second_word;
         start_in      = in_chunk_start;
         cnt_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         start_ff      <= 1'b0;
         cnt_ff        <= '0;
         err_ff        <= ssrc_pkg::RESET_ERROR;
         skip_ff       <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         start_ff      <= start_in;
         cnt_ff        <= cnt_in;
         err_ff        <= err_in;
         skip_ff       <= skip_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      slot_ff   <= slot_in;
      full_ff   <= full_in;
      last_ff   <= last_in;
   end

   assign out_valid            = rsp_valid_ff;
   assign out_low_slot_sample  = low_ff;
   assign out_high_slot_sample = high_ff;
   assign out_slot_position    = slot_ff;
   assign out_buffer_full      = full_ff;
   assign out_last_of_run      = last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/stereo_sample_rate_converter.sv -----
// An accepted frame is registered in the input stage; its results are registered in the result stage.
// Throughput: at most one result per cycle, with rsp_stall low and the divider idle; a frame
//   holds the input stage through its last step, and the next frame enters at that step's edge.
// A source_rate or dest_rate write re-runs the stride divider (shift-subtract, one quotient bit
//   a cycle): frames stall in the write cycle and while the divider is busy.
// Reset (synchronous): registers to defaults, stride 1, both stages empty; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stereo_sample_rate_converter #(
   parameter int MAX_BUFFER_FRAMES = 8192,
   parameter int MAX_REPEAT        = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic signed [ssrc_pkg::SAMPLE_W-1:0]  req_first_word,
   input  wire logic signed [ssrc_pkg::SAMPLE_W-1:0]  req_second_word,
   input  wire logic                                  req_chunk_start,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic signed [ssrc_pkg::SAMPLE_W-1:0]  rsp_low_slot_sample,
   output      logic signed [ssrc_pkg::SAMPLE_W-1:0]  rsp_high_slot_sample,
   output      logic [ssrc_pkg::SLOT_W-1:0]           rsp_slot_position,
   output      logic                                  rsp_buffer_full,
   output      logic                                  rsp_last_of_run,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [ssrc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ssrc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SRC_RATE_W = ssrc_pkg::SRC_RATE_W;
   localparam int DST_RATE_W = ssrc_pkg::DST_RATE_W;
   localparam int LEN_W      = ssrc_pkg::LEN_W;

   ssrc_pkg::cfg_type         cfg_ff, cfg_in;
   ssrc_pkg::stride_stat_type stride_stat;

   logic csr_write;
   logic rate_write;
   logic core_ready;
   logic req_take;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign rate_write = csr_write && (csr_index == ssrc_pkg::REG_SOURCE_RATE ||
                                     csr_index == ssrc_pkg::REG_DEST_RATE);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            ssrc_pkg::REG_SOURCE_RATE:   cfg_in.source_rate   = csr_wdata[SRC_RATE_W-1:0];
            ssrc_pkg::REG_DEST_RATE:     cfg_in.dest_rate     = csr_wdata[DST_RATE_W-1:0];
            ssrc_pkg::REG_WORD_SWAP:     cfg_in.word_swap     = csr_wdata[0];
            ssrc_pkg::REG_BUFFER_LENGTH: cfg_in.buffer_length = csr_wdata[LEN_W-1:0];
            default: begin
               // drop writes to unmapped registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_rate   <= ssrc_pkg::RESET_SOURCE_RATE;
         cfg_ff.dest_rate     <= ssrc_pkg::RESET_DEST_RATE;
         cfg_ff.word_swap     <= ssrc_pkg::RESET_WORD_SWAP;
         cfg_ff.buffer_length <= ssrc_pkg::RESET_BUFFER_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssrc_stride_div u_stride_div (
      .clock (clock),
      .reset (reset),
      .start (rate_write),
      .cfg   (cfg_ff),
      .stat  (stride_stat)
   );

   // hold frames off during a CSR write, while the stride is being worked out, or while the core cannot take one
   assign req_stall = csr_write || stride_stat.busy || !core_ready;
   assign req_take  = req_valid && !req_stall;

   ssrc_frame_core #(
      .MAX_BUFFER_FRAMES (MAX_BUFFER_FRAMES),
      .MAX_REPEAT        (MAX_REPEAT)
   ) u_frame_core (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .stride               (stride_stat.stride),
      .in_take              (req_take),
      .in_first_word        (req_first_word),
      .in_second_word       (req_second_word),
      .in_chunk_start       (req_chunk_start),
      .in_ready             (core_ready),
      .out_valid            (rsp_valid),
      .out_stall            (rsp_stall),
      .out_low_slot_sample  (rsp_low_slot_sample),
      .out_high_slot_sample (rsp_high_slot_sample),
      .out_slot_position    (rsp_slot_position),
      .out_buffer_full      (rsp_buffer_full),
      .out_last_of_run      (rsp_last_of_run)
   );

   a_stride_nonzero: assert property (@(posedge clock) disable iff (reset)
      !stride_stat.busy |-> stride_stat.stride != '0)
      else $error("skip stride is zero once the divider has settled");

   a_rate_write_busy: assert property (@(posedge clock) disable iff (reset)
      rate_write |=> stride_stat.busy)
      else $error("rate write did not start the stride divider");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("repeat run broke off before its last beat");

endmodule

`default_nettype wire
